>>> rtl/bppr_pkg.sv
`default_nettype none

package bppr_pkg;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_PIXEL_FORMAT = 1'b1;

  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 13;

  // Pixel formats
  localparam logic FMT_RGB24  = 1'b0;
  localparam logic FMT_RGBA32 = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // One classified pixel, handed from the front end to the byte sequencer
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       fmt;
    logic [1:0] pad;
  } pix_cmd_t;

  // One result byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
  } out_byte_t;

endpackage

`default_nettype wire

>>> rtl/bitmap_pixel_row_packer_unit.sv
`default_nettype none

// Bitmap pixel row packer. Push one RGBA pixel per transfer, bottom row first
// and left to right; pop the pixel data stream one byte per transfer. In 24-bit
// mode (pixel_format 0) each pixel gives red, green, blue composited over white,
// floor(c*a/255)+255-a, or c unchanged when alpha is 255; in 32-bit mode it
// gives red, green, blue, alpha unchanged. The last pixel of a row (found by a
// column counter against image_width, clamped to 1..MAX_WIDTH) is followed in
// 24-bit mode by clamped-width mod 4 zero bytes. run_last marks the final byte
// caused by each pixel. The output drains one byte per clock while the output
// buffer has room; pixels are taken back to back while a two-entry command
// queue has room. A pushed pixel passes the command queue, the back-end pixel
// register and the output buffer before its first byte appears. Write the
// configuration only while the unit is drained.
module bitmap_pixel_row_packer_unit
  import bppr_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  // pixel input
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  input  wire logic [7:0]           in_alpha,
  // byte output
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [7:0]                out_data_byte,
  output logic                      out_run_last
);

  pix_cmd_t  front_cmd;
  pix_cmd_t  cmd_dout;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      in_accept;
  logic      obuf_full;
  logic      obuf_push;
  out_byte_t obuf_din;
  out_byte_t obuf_dout;

  // A pixel transfer completes whenever the command queue has room
  assign in_accept = in_push && !in_full;

  // Front end: configuration registers, column counter, pad classification
  bppr_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .alpha     (in_alpha),
    .cmd       (front_cmd)
  );

  // Decouple the classifier from the byte sequencer
  bppr_fifo #(
    .W($bits(pix_cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  // Back end: emit one byte per cycle while the output buffer has room, blending in 24-bit mode
  bppr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_dout  (cmd_dout),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (obuf_full),
    .out_push  (obuf_push),
    .out_din   (obuf_din)
  );

  // Output buffer: hold finished bytes while the consumer stalls
  bppr_fifo #(
    .W($bits(out_byte_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (obuf_push),
    .din   (obuf_din),
    .full  (obuf_full),
    .pop   (out_pop),
    .dout  (obuf_dout),
    .empty (out_empty)
  );

  assign out_data_byte = obuf_dout.data_byte;
  assign out_run_last  = obuf_dout.run_last;

endmodule

`default_nettype wire

>>> rtl/bppr_fifo.sv
`default_nettype none

module bppr_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("fifo count out of range");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("fifo empty after a lone push");

endmodule

`default_nettype wire

>>> rtl/bppr_front.sv
`default_nettype none

module bppr_front
  import bppr_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  input  wire logic                 accept,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           alpha,
  output pix_cmd_t                  cmd
);

  localparam int WW = ($clog2(MAX_WIDTH + 1) > CfgDataW) ? $clog2(MAX_WIDTH + 1) : CfgDataW;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CfgDataW-1:0] image_width_r;
  logic                pixel_format_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [WW-1:0]       width_ext;
  logic [WW-1:0]       eff_width;
  logic [WW-1:0]       col_plus;
  logic                row_end;

  // Clamp the programmed width into 1..MAX_WIDTH
  always_comb begin
    width_ext = WW'(image_width_r);
    priority if (width_ext == '0) begin
      eff_width = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
  end

  assign col_plus = WW'(col_r) + WW'(1);
  assign row_end  = (col_plus >= eff_width);
  assign col_nxt  = row_end ? '0 : CW'(col_plus);

  always_comb begin
    cmd.red   = red;
    cmd.green = green;
    cmd.blue  = blue;
    cmd.alpha = alpha;
    cmd.fmt   = pixel_format_r;
    cmd.pad   = (row_end && pixel_format_r == FMT_RGB24) ? eff_width[1:0] : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= CfgDataW'(1);
      pixel_format_r <= FMT_RGB24;
      col_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
          CFG_PIXEL_FORMAT: pixel_format_r <= cfg_data[0];
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
      end
    end
  end

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < WW'(MAX_WIDTH))
    else $error("column counter beyond maximum width");

endmodule

`default_nettype wire

>>> rtl/bppr_back.sv
`default_nettype none

module bppr_back
  import bppr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire pix_cmd_t cmd_dout,
  input  wire logic     cmd_empty,
  output logic          cmd_pop,
  input  wire logic     out_full,
  output logic          out_push,
  output out_byte_t     out_din
);

  pix_cmd_t    cur_r;
  logic        busy_r;
  logic [2:0]  idx_r;
  logic [2:0]  n_bytes;
  logic        last;
  logic        emit;
  logic        load;
  logic [7:0]  comp;
  logic [15:0] prod;
  logic [16:0] quot_sum;
  logic [7:0]  blended;
  logic [7:0]  byte_val;

  assign n_bytes = (cur_r.fmt == FMT_RGBA32) ? 3'd4 : (3'd3 + {1'b0, cur_r.pad});
  assign last    = (idx_r == n_bytes - 3'd1);
  assign emit    = busy_r && !out_full;
  assign load    = (!busy_r || (emit && last)) && !cmd_empty;
  assign cmd_pop = load;

  always_comb begin
    unique case (idx_r)
      3'd0:    comp = cur_r.red;
      3'd1:    comp = cur_r.green;
      3'd2:    comp = cur_r.blue;
      default: comp = 8'd0;
    endcase
  end

  // floor(c*a/255) by multiply-add-shift, exact for the products that reach it (a below 255)
  assign prod     = comp * cur_r.alpha;
  assign quot_sum = 17'(prod) + 17'(prod >> 8) + 17'd1;
  assign blended  = (cur_r.alpha == ALPHA_OPAQUE) ? comp : (quot_sum[15:8] + ~cur_r.alpha);

  always_comb begin
    if (cur_r.fmt == FMT_RGBA32) begin
      byte_val = (idx_r == 3'd3) ? cur_r.alpha : comp;
    end else begin
      byte_val = (idx_r < 3'd3) ? blended : 8'd0;
    end
  end

  assign out_push          = emit;
  assign out_din.data_byte = byte_val;
  assign out_din.run_last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      priority if (load) begin
        busy_r <= 1'b1;
        idx_r  <= 3'd0;
      end else if (emit && last) begin
        busy_r <= 1'b0;
        idx_r  <= 3'd0;
      end else if (emit) begin
        idx_r  <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= cmd_dout;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < n_bytes))
    else $error("byte index past end of pixel");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (idx_r == 3'd0))
    else $error("byte index not cleared while idle");

endmodule

`default_nettype wire
